// ----- design/rv_pkg.sv -----
`timescale 1ns / 1ps
package rv_pkg;

    // Window and ring geometry
    localparam int WINDOW_MAX = 256;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W     = $clog2(WINDOW_MAX);
    localparam int LEN_RESET  = 20;

    // Field and sum widths
    localparam int CFG_W   = 9;
    localparam int PRICE_W = 20;
    localparam int PS_W    = 22;
    localparam int VOL_W   = 32;
    localparam int PROD_W  = PS_W + VOL_W;
    localparam int WS_W    = 62;
    localparam int VS_W    = 40;
    localparam int FRAC_W  = 8;
    localparam int Q_W     = 28;
    localparam int NUM_W   = WS_W + FRAC_W;
    localparam int DEN_W   = VS_W + 2;
    localparam int REM_W   = DEN_W + 1;
    localparam int CNT_W   = $clog2(Q_W);
    localparam int RING_W  = PS_W + VOL_W;
    localparam int CLAMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    typedef struct packed {
        logic accept;    // latch the bar, read the oldest slot
        logic mul_old;   // multiply oldest entry, write the new one
        logic sub_old;   // drop oldest bar from the sums, multiply new bar
        logic add_new;   // add new bar, advance slot and count
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;      // this bar completes or extends a full window
    } t_dp_sts;

    // Clamp a written window length to 1..WINDOW_MAX
    function automatic logic [LEN_W-1:0] f_clamp_len(input logic [CFG_W-1:0] cfg);
        logic [CLAMP_W-1:0] wide;
        wide = CLAMP_W'(cfg);
        if (wide == '0) begin
            return LEN_W'(1);
        end else if (wide > CLAMP_W'(WINDOW_MAX)) begin
            return LEN_W'(WINDOW_MAX);
        end else begin
            return wide[LEN_W-1:0];
        end
    endfunction

endpackage

// ----- design/rolling_vwap.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// cfg       in         i_cfg_we                     i_cfg_wdata (window_length, 9b)
// bar       in         i_bar_valid / o_bar_ready    i_high_price, i_low_price,
//                                                   i_close_price, i_bar_volume
// vwap      out        o_vwap_valid / i_vwap_ready  o_vwap_value (28b, 8 frac bits)
//
// A bar that does not complete a window goes through the ring read, two shared
// 22x32 multiplies and the sum updates; one that yields a result then also
// loads the divider, runs the bit-serial divider and loads the output
// register.
// A result still waiting on the output holds the block only at that last load.
// Synchronous active-low reset restores window length 20 and empty sums;
// the ring memory needs no clearing, since an unwritten slot is never used.
module rolling_vwap
    import rv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_bar_valid,
    output logic               o_bar_ready,
    input  logic [PRICE_W-1:0] i_high_price,
    input  logic [PRICE_W-1:0] i_low_price,
    input  logic [PRICE_W-1:0] i_close_price,
    input  logic [VOL_W-1:0]   i_bar_volume,
    output logic               o_vwap_valid,
    input  logic               i_vwap_ready,
    output logic [Q_W-1:0]     o_vwap_value
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bar_valid  (i_bar_valid),
        .o_bar_ready  (o_bar_ready),
        .o_vwap_valid (o_vwap_valid),
        .i_vwap_ready (i_vwap_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    rv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_high_price  (i_high_price),
        .i_low_price   (i_low_price),
        .i_close_price (i_close_price),
        .i_bar_volume  (i_bar_volume),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_vwap_value  (o_vwap_value)
    );

endmodule

// ----- design/rv_ram.sv -----
`timescale 1ns / 1ps
module rv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rv_dp.sv -----
`timescale 1ns / 1ps
module rv_dp
    import rv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [PRICE_W-1:0] i_high_price,
    input  logic [PRICE_W-1:0] i_low_price,
    input  logic [PRICE_W-1:0] i_close_price,
    input  logic [VOL_W-1:0]   i_bar_volume,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic [Q_W-1:0]     o_vwap_value
);

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_bars;
    logic [SLOT_W-1:0] r_slot;
    logic [WS_W-1:0]   r_ws;
    logic [VS_W-1:0]   r_vs;
    logic [PS_W-1:0]   r_psum;
    logic [VOL_W-1:0]  r_vol;
    logic [PROD_W-1:0] r_prod;
    logic [DEN_W-1:0]  r_den;
    logic [REM_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_quo;
    logic              r_ws_zero;
    logic [Q_W-1:0]    r_vwap;

    logic [RING_W-1:0] ring_rdata;
    logic [PS_W-1:0]   old_psum;
    logic [VOL_W-1:0]  old_vol;
    logic [PS_W-1:0]   mul_a;
    logic [VOL_W-1:0]  mul_b;
    logic [PROD_W-1:0] n_prod;
    logic              full;
    logic [LEN_W-1:0]  bars_inc;
    logic [LEN_W-1:0]  slot_inc;
    logic [NUM_W-1:0]  num;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  den_ext;
    logic              fits;

    rv_ram #(
        .WIDTH (RING_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mul_old),
        .i_waddr (r_slot),
        .i_wdata ({r_psum, r_vol}),
        .i_re    (i_cmd.accept),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    assign old_psum = ring_rdata[RING_W-1:VOL_W];
    assign old_vol  = ring_rdata[VOL_W-1:0];

    // One multiplier, shared by the leaving bar and the arriving bar
    assign mul_a  = i_cmd.mul_old ? old_psum : r_psum;
    assign mul_b  = i_cmd.mul_old ? old_vol  : r_vol;
    assign n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign full     = (r_bars == r_len);
    assign bars_inc = r_bars + LEN_W'(1);
    assign slot_inc = LEN_W'(r_slot) + LEN_W'(1);
    assign o_sts.emit = full || (bars_inc == r_len);

    // Restoring divide of {ws, 8 zero bits} by 3*vs, one quotient bit a cycle
    assign num     = {r_ws, FRAC_W'(0)};
    assign trial   = {r_rem[REM_W-2:0], r_quo[Q_W-1]};
    assign den_ext = REM_W'(r_den);
    assign fits    = (trial >= den_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= f_clamp_len(CFG_W'(LEN_RESET));
            r_bars <= '0;
            r_slot <= '0;
            r_ws   <= '0;
            r_vs   <= '0;
        end else if (i_cfg_we) begin
            r_len  <= f_clamp_len(i_cfg_wdata);
            r_bars <= '0;
            r_slot <= '0;
            r_ws   <= '0;
            r_vs   <= '0;
        end else begin
            if (i_cmd.sub_old && full) begin
                r_ws <= r_ws - WS_W'(r_prod);
                r_vs <= r_vs - VS_W'(old_vol);
            end
            if (i_cmd.add_new) begin
                r_ws   <= r_ws + WS_W'(r_prod);
                r_vs   <= r_vs + VS_W'(r_vol);
                r_slot <= (slot_inc == r_len) ? '0 : slot_inc[SLOT_W-1:0];
                if (!full) begin
                    r_bars <= bars_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_psum <= PS_W'(i_high_price) + PS_W'(i_low_price) + PS_W'(i_close_price);
            r_vol  <= i_bar_volume;
        end
        if (i_cmd.mul_old || i_cmd.sub_old) begin
            r_prod <= n_prod;
        end
        if (i_cmd.div_init) begin
            r_den     <= DEN_W'(r_vs) + {r_vs, 1'b0};
            r_rem     <= REM_W'(num[NUM_W-1:Q_W]);
            r_quo     <= num[Q_W-1:0];
            r_ws_zero <= (r_ws == '0);
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? (trial - den_ext) : trial;
            r_quo <= {r_quo[Q_W-2:0], fits};
        end
        if (i_cmd.out_load) begin
            r_vwap <= r_ws_zero ? '0 : r_quo;
        end
    end

    assign o_vwap_value = r_vwap;

endmodule

// ----- design/rv_ctrl.sv -----
`timescale 1ns / 1ps
module rv_ctrl
    import rv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_bar_valid,
    output logic    o_bar_ready,
    output logic    o_vwap_valid,
    input  logic    i_vwap_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_ADD,
        ST_INIT,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    logic accept;
    logic out_free;

    assign accept   = (r_state == ST_IDLE) && i_bar_valid;
    assign out_free = !r_out_valid || i_vwap_ready;

    assign o_bar_ready    = (r_state == ST_IDLE);
    assign o_vwap_valid   = r_out_valid;

    assign o_cmd.accept   = accept;
    assign o_cmd.mul_old  = (r_state == ST_MUL);
    assign o_cmd.sub_old  = (r_state == ST_SUB);
    assign o_cmd.add_new  = (r_state == ST_ADD);
    assign o_cmd.div_init = (r_state == ST_INIT);
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_cmd.out_load = (r_state == ST_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the beat once taken; raise it again on a new load
            r_out_valid <= ((r_state == ST_OUT) && out_free) ||
                           (r_out_valid && !i_vwap_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.emit ? ST_INIT : ST_IDLE;
                end
                ST_INIT: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import rv_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [PRICE_W-1:0] high_px;
        logic [PRICE_W-1:0] low_px;
        logic [PRICE_W-1:0] close_px;
        logic [VOL_W-1:0]   volume;
    } t_bar;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;
    logic               i_bar_valid   = 1'b0;
    logic               o_bar_ready;
    logic [PRICE_W-1:0] i_high_price  = '0;
    logic [PRICE_W-1:0] i_low_price   = '0;
    logic [PRICE_W-1:0] i_close_price = '0;
    logic [VOL_W-1:0]   i_bar_volume  = '0;
    logic               o_vwap_valid;
    logic               i_vwap_ready  = 1'b0;
    logic [Q_W-1:0]     o_vwap_value;

    rolling_vwap uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_bar_valid   (i_bar_valid),
        .o_bar_ready   (o_bar_ready),
        .i_high_price  (i_high_price),
        .i_low_price   (i_low_price),
        .i_close_price (i_close_price),
        .i_bar_volume  (i_bar_volume),
        .o_vwap_valid  (o_vwap_valid),
        .i_vwap_ready  (i_vwap_ready),
        .o_vwap_value  (o_vwap_value)
    );

    // Window state mirrored from the block
    logic [CFG_W-1:0] win_cfg = CFG_W'(LEN_RESET);
    logic [PS_W-1:0]  ring_psum [WINDOW_MAX];
    logic [VOL_W-1:0] ring_vol  [WINDOW_MAX];
    logic [WS_W-1:0]  win_wsum  = '0;
    logic [VS_W-1:0]  win_vsum  = '0;
    int unsigned      win_seen  = 0;
    int unsigned      win_slot  = 0;

    logic [Q_W-1:0]   expected_vwap [$];
    logic [Q_W-1:0]   vwap_want;

    int               failures       = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_id        = 0;
    int               hold_taken     = 0;
    int               hold_left      = 0;
    int               cycle_count    = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_MAX) begin
            $display("vwap mismatch: %s", what);
        end
    endfunction

    function automatic int unsigned window_span();
        if (win_cfg == '0) begin
            return 1;
        end
        if (int'(win_cfg) > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(win_cfg);
    endfunction

    // Fold one bar into the window and queue the VWAP it produces, if any
    function automatic void absorb_bar(input t_bar b);
        int unsigned      span;
        int unsigned      s;
        logic [PS_W-1:0]  psum;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        logic [NUM_W-1:0] quo;
        span = window_span();
        s = (win_slot >= span) ? 0 : win_slot;
        psum = PS_W'(b.high_px) + PS_W'(b.low_px) + PS_W'(b.close_px);
        if (win_seen >= span) begin
            // drop the oldest bar, which sits in the slot about to be reused
            win_wsum = win_wsum - WS_W'(ring_psum[s]) * WS_W'(ring_vol[s]);
            win_vsum = win_vsum - VS_W'(ring_vol[s]);
        end
        ring_psum[s] = psum;
        ring_vol[s] = b.volume;
        win_wsum = win_wsum + WS_W'(psum) * WS_W'(b.volume);
        win_vsum = win_vsum + VS_W'(b.volume);
        s = s + 1;
        if (s >= span) begin
            s = 0;
        end
        win_slot = s;
        if (win_seen < span) begin
            win_seen = win_seen + 1;
        end
        if (win_seen >= span) begin
            if (win_wsum == '0 || win_vsum == '0) begin
                quo = '0;
            end else begin
                num = {win_wsum, FRAC_W'(0)};
                den = NUM_W'(win_vsum) * NUM_W'(3);
                quo = num / den;
            end
            expected_vwap.push_back(quo[Q_W-1:0]);
        end
    endfunction

    function automatic t_bar random_bar();
        t_bar b;
        b.high_px  = PRICE_W'($urandom);
        b.low_px   = PRICE_W'($urandom);
        b.close_px = PRICE_W'($urandom);
        b.volume   = VOL_W'($urandom);
        case ($urandom_range(9))
            0: b.volume = '0;
            1: b.volume = VOL_W'($urandom_range(15));
            2: begin
                b.high_px  = '1;
                b.low_px   = '1;
                b.close_px = '1;
            end
            3: begin
                b.high_px  = PRICE_W'($urandom_range(255));
                b.low_px   = PRICE_W'($urandom_range(255));
                b.close_px = PRICE_W'($urandom_range(255));
            end
            4: b.volume = '1;
            default: ;
        endcase
        return b;
    endfunction

    // Enter and leave at a falling edge; valid stays up for the next beat
    task automatic send_bar(input t_bar b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_bar_valid = 1'b0;
            @(negedge i_clk);
        end
        {i_high_price, i_low_price, i_close_price, i_bar_volume} = b;
        i_bar_valid = 1'b1;
        @(posedge i_clk);
        while (!o_bar_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        absorb_bar(b);
    endtask

    task automatic run_bars(input int count);
        repeat (count) begin
            send_bar(random_bar());
        end
    endtask

    task automatic drain_results();
        i_bar_valid = 1'b0;
        while (expected_vwap.size() != 0) begin
            @(negedge i_clk);
        end
        // let a bar that yields nothing finish before touching the register
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        win_cfg = value;
        win_wsum = '0;
        win_vsum = '0;
        win_seen = 0;
        win_slot = 0;
    endtask

    // Call only with valid low
    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        @(negedge i_clk);
    endtask

    task automatic test_default_window();
        set_idling(0, 0);
        run_bars(30);
    endtask

    task automatic test_field_extremes();
        write_window(CFG_W'(0));
        set_idling(0, 0);
        send_bar('{'0, '0, '0, '0});
        send_bar('{'1, '1, '1, '1});
        send_bar('{'1, '1, '1, '0});
        send_bar('{'0, '0, '0, '1});
        send_bar('{'1, '0, '0, VOL_W'(1)});
        send_bar('{PRICE_W'(20'hAAAAA), PRICE_W'(20'h55555), PRICE_W'(20'h12345),
                   VOL_W'(32'h8000_0001)});
        // two-bar window: eviction, and a zero weighted sum with volume present
        write_window(CFG_W'(2));
        send_bar('{'1, '1, '1, '1});
        send_bar('{'0, '0, '0, '1});
        send_bar('{'0, '0, PRICE_W'(3), '0});
        send_bar('{'1, '1, '1, VOL_W'(1)});
        send_bar('{PRICE_W'(1), '0, '0, '1});
    endtask

    task automatic test_short_windows();
        write_window(CFG_W'(5));
        set_idling(0, 0);
        run_bars(70);
        write_window(CFG_W'(1));
        set_idling(51, 0);
        run_bars(60);
    endtask

    task automatic test_random_windows();
        write_window(CFG_W'($urandom_range(40, 2)));
        set_idling(0, 51);
        run_bars(100);
        write_window(CFG_W'($urandom_range(16, 3)));
        set_idling(32, 32);
        run_bars(90);
    endtask

    task automatic test_full_window();
        write_window(CFG_W'(WINDOW_MAX));
        set_idling(32, 32);
        run_bars(262);
    endtask

    task automatic test_oversize_window();
        write_window(CFG_W'(511));
        set_idling(0, 0);
        run_bars(262);
    endtask

    task automatic test_output_backpressure();
        write_window(CFG_W'(1));
        set_idling(0, 0);
        @(posedge i_clk);
        hold_id++;
        @(negedge i_clk);
        run_bars(24);
    endtask

    task automatic test_sender_pause();
        write_window(CFG_W'(3));
        set_idling(51, 51);
        run_bars(20);
        i_bar_valid = 1'b0;
        while (expected_vwap.size() != 0) begin
            @(negedge i_clk);
        end
        run_bars(20);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_id != hold_taken) begin
            hold_taken <= hold_id;
            hold_left <= HOLD_CYCLES - 1;
            i_vwap_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_vwap_ready <= 1'b0;
        end else begin
            i_vwap_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_vwap_valid && i_vwap_ready) begin
            if (expected_vwap.size() == 0) begin
                note_failure($sformatf("unexpected beat, actual %h", o_vwap_value));
            end else begin
                vwap_want = expected_vwap.pop_front();
                if (o_vwap_value !== vwap_want) begin
                    note_failure($sformatf("expected %h, actual %h", vwap_want,
                                           o_vwap_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** rolling_vwap: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_window();
        test_field_extremes();
        test_short_windows();
        test_random_windows();
        test_full_window();
        test_oversize_window();
        test_output_backpressure();
        test_sender_pause();
        drain_results();
        if (failures == 0 && expected_vwap.size() == 0) begin
            $display("** rolling_vwap: PASSED **");
        end else begin
            $display("** rolling_vwap: FAILED **");
        end
        $finish;
    end

endmodule
